// File: src/pir_pkg.sv
// Shared types and constants for the point-in-region classifier.
// Holds the item opcodes and the stream bus field layout.
// No dependencies.
package pir_pkg;

  // Operation codes carried in the slave-side tuser
  typedef enum logic [1:0] {
    OP_WR_VERTEX = 2'd0,
    OP_WR_HEADER = 2'd1,
    OP_QUERY     = 2'd2
  } op_e;

  // Field widths
  localparam int OP_W     = 2;
  localparam int REGION_W = 5;
  localparam int VERTEX_W = 6;
  localparam int COORD_W  = 32;
  localparam int LABEL_W  = 16;
  localparam int COUNT_W  = 7;

  // Slave-side tdata layout, lowest bit first
  localparam int REGION_LSB = 0;
  localparam int VERTEX_LSB = REGION_LSB + REGION_W;
  localparam int PX_LSB     = VERTEX_LSB + VERTEX_W;
  localparam int PY_LSB     = PX_LSB + COORD_W;
  localparam int LABEL_LSB  = PY_LSB + COORD_W;
  localparam int COUNT_LSB  = LABEL_LSB + LABEL_W;
  localparam int S_USED_W   = COUNT_LSB + COUNT_W;
  localparam int S_TDATA_W  = ((S_USED_W + 7) / 8) * 8;

  // Master-side tdata holds only the label
  localparam int M_TDATA_W  = ((LABEL_W + 7) / 8) * 8;

endpackage

// File: src/point_in_region_classifier.sv
// Point-in-region classifier: even-odd ray crossing test over stored polygons.
// Depends on pir_pkg and pir_ram.
//
// Usage: one slave stream carries items, tuser selecting the operation
// (vertex write, region header write, query). A write beat gives no result.
// A query beat starts a walk over the regions in
// slot order; the master stream then returns one beat with tuser = found and
// tdata = label of the first region that holds the point (0 if none).
// Query steps: each region's header is read and checked, and an empty
// region is skipped; otherwise vertex 0 is fetched and each edge is loaded,
// a straddling edge going through difference, two multiplies and compare;
// the result is then posted. Query time is set by the single shared 32x32
// multiplier, used twice per straddling edge, and by the one read port of
// the vertex memory. No new item is taken during a query.
// Reset clears the region valid bits (all regions empty) and the sequencer;
// vertex and label storage are not cleared and need no clearing pass.
// A stalled master side holds the result beat; a finished query waits for
// the result register to free before the block turns ready again, while
// write beats are taken as soon as the block is idle.
module point_in_region_classifier #(
  parameter int REGIONS      = 32,
  parameter int MAX_VERTICES = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // slave side: tuser = op; tdata = region, vertex, px, py, label_in, count_in
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [pir_pkg::OP_W-1:0]       s_axis_tuser,
  input  logic [pir_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // master side: tuser = found; tdata = label_out
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic                           m_axis_tuser,
  output logic [pir_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
  import pir_pkg::*;

  localparam int RW     = (REGIONS > 1) ? $clog2(REGIONS) : 1;
  localparam int CW     = $clog2(MAX_VERTICES + 1);
  localparam int VDEPTH = REGIONS * MAX_VERTICES;
  localparam int VA     = (VDEPTH > 1) ? $clog2(VDEPTH) : 1;
  localparam int HW     = LABEL_W + CW;

  typedef enum logic [11:0] {
    ST_IDLE = 12'b0000_0000_0001,
    ST_HDR  = 12'b0000_0000_0010,
    ST_HCHK = 12'b0000_0000_0100,
    ST_V0   = 12'b0000_0000_1000,
    ST_LOAD = 12'b0000_0001_0000,
    ST_DIFF = 12'b0000_0010_0000,
    ST_MULA = 12'b0000_0100_0000,
    ST_MULC = 12'b0000_1000_0000,
    ST_CMP  = 12'b0001_0000_0000,
    ST_ENDE = 12'b0010_0000_0000,
    ST_NXR  = 12'b0100_0000_0000,
    ST_DONE = 12'b1000_0000_0000
  } state_e;

  // Control state
  state_e              state_q, state_d;
  logic [RW-1:0]       r_q, r_d;
  logic [VA-1:0]       base_q, base_d;
  logic [CW-1:0]       idx_q, idx_d;
  logic [CW-1:0]       n_q, n_d;
  logic                closing_q, closing_d;
  logic                parity_q, parity_d;
  logic [REGIONS-1:0]  hdr_valid_q, hdr_valid_d;
  logic                m_valid_q, m_valid_d;

  // Payload registers
  logic [COORD_W-1:0]  px_q, px_d, py_q, py_d;
  logic [LABEL_W-1:0]  label_q, label_d;
  logic [COORD_W-1:0]  v0x_q, v0x_d, v0y_q, v0y_d;
  logic [COORD_W-1:0]  curx_q, curx_d, cury_q, cury_d;
  logic [COORD_W-1:0]  xl_q, xl_d, yl_q, yl_d, xh_q, xh_d, yh_q, yh_d;
  logic [COORD_W-1:0]  mag_a_q, mag_a_d, mag_c_q, mag_c_d;
  logic                sign_a_q, sign_a_d, sign_c_q, sign_c_d;
  logic [COORD_W-1:0]  dy_q, dy_d, d_q, d_d;
  logic [2*COORD_W-1:0] prod_a_q, prod_a_d, prod_c_q, prod_c_d;
  logic                res_found_q, res_found_d;
  logic [LABEL_W-1:0]  m_label_q, m_label_d;
  logic                m_found_q, m_found_d;

  // Unpacked input fields
  logic [REGION_W-1:0] in_region;
  logic [VERTEX_W-1:0] in_vertex;
  logic [COORD_W-1:0]  in_px, in_py;
  logic [LABEL_W-1:0]  in_label;
  logic [COUNT_W-1:0]  in_count;
  logic                in_fire;
  logic                region_ok, vertex_ok;
  logic [RW-1:0]       wr_r;
  logic [CW-1:0]       cnt_sat;

  // Memory ports
  logic                vram_we, vram_re;
  logic [VA-1:0]       vram_waddr, vram_raddr;
  logic [2*COORD_W-1:0] vram_wdata, vram_rdata;
  logic                hram_we, hram_re;
  logic [RW-1:0]       hram_waddr;
  logic [HW-1:0]       hram_wdata, hram_rdata;

  // Datapath helpers
  logic [CW-1:0]       hdr_cnt, n_rd;
  logic [CW-1:0]       adv_k, rd_idx;
  logic                adv_last;
  logic [COORD_W-1:0]  e1x, e1y;
  logic                gt0, gt1, straddle;
  logic [COORD_W:0]    a_w, c_w, a_neg, c_neg, dy_w, d_w;
  logic [COORD_W-1:0]  mul_x, mul_y;
  logic [2*COORD_W-1:0] mul_p;
  logic                na, nc, less;
  logic                r_last;

  // Unpack the slave beat
  assign in_region = s_axis_tdata[REGION_LSB +: REGION_W];
  assign in_vertex = s_axis_tdata[VERTEX_LSB +: VERTEX_W];
  assign in_px     = s_axis_tdata[PX_LSB +: COORD_W];
  assign in_py     = s_axis_tdata[PY_LSB +: COORD_W];
  assign in_label  = s_axis_tdata[LABEL_LSB +: LABEL_W];
  assign in_count  = s_axis_tdata[COUNT_LSB +: COUNT_W];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid & s_axis_tready;

  assign region_ok = (32'(in_region) < REGIONS);
  assign vertex_ok = (32'(in_vertex) < MAX_VERTICES);
  assign wr_r      = RW'(in_region);
  assign cnt_sat   = (32'(in_count) > MAX_VERTICES) ? CW'(MAX_VERTICES) : CW'(in_count);

  // Write ports, driven straight from an accepted write beat
  assign vram_we    = in_fire && (s_axis_tuser == OP_WR_VERTEX) && region_ok && vertex_ok;
  assign vram_waddr = VA'(wr_r) * VA'(MAX_VERTICES) + VA'(in_vertex);
  assign vram_wdata = {in_py, in_px};
  assign hram_we    = in_fire && (s_axis_tuser == OP_WR_HEADER) && region_ok;
  assign hram_waddr = wr_r;
  assign hram_wdata = {in_label, cnt_sat};

  // Header read data; a region never written counts as empty
  assign hdr_cnt = hram_rdata[CW-1:0];
  assign n_rd    = hdr_valid_q[r_q] ? hdr_cnt : '0;
  assign r_last  = (r_q == RW'(REGIONS - 1));

  // Next vertex to fetch: vertex 1 while vertex 0 is read out, else the one after idx
  assign adv_k      = (state_q == ST_V0) ? CW'(1) : idx_q + CW'(1);
  assign adv_last   = (adv_k == n_q);
  assign rd_idx     = (state_q == ST_HCHK) ? '0 : adv_k;
  assign vram_raddr = base_q + VA'(rd_idx);
  assign hram_re    = (state_q == ST_HDR);
  assign vram_re    = (state_q == ST_HCHK) ||
                      (((state_q == ST_V0) || (state_q == ST_ENDE)) && !adv_last);

  // Edge endpoints: the closing edge wraps back to vertex 0
  assign e1x      = closing_q ? v0x_q : vram_rdata[COORD_W-1:0];
  assign e1y      = closing_q ? v0y_q : vram_rdata[2*COORD_W-1:COORD_W];
  assign gt0      = ($signed(cury_q) > $signed(py_q));
  assign gt1      = ($signed(e1y) > $signed(py_q));
  assign straddle = gt0 ^ gt1;

  // Differences against the lower endpoint
  assign a_w   = {px_q[COORD_W-1], px_q} - {xl_q[COORD_W-1], xl_q};
  assign c_w   = {xh_q[COORD_W-1], xh_q} - {xl_q[COORD_W-1], xl_q};
  assign a_neg = '0 - a_w;
  assign c_neg = '0 - c_w;
  assign dy_w  = {yh_q[COORD_W-1], yh_q} - {yl_q[COORD_W-1], yl_q};
  assign d_w   = {py_q[COORD_W-1], py_q} - {yl_q[COORD_W-1], yl_q};

  // Shared multiplier: |a| * dy, then |c| * d
  assign mul_x = (state_q == ST_MULA) ? mag_a_q : mag_c_q;
  assign mul_y = (state_q == ST_MULA) ? dy_q : d_q;
  assign mul_p = mul_x * mul_y;

  // Signed compare of the two products: px left of the edge crossing
  assign na   = sign_a_q & (prod_a_q != '0);
  assign nc   = sign_c_q & (prod_c_q != '0);
  assign less = (na != nc) ? na : (na ? (prod_a_q > prod_c_q) : (prod_a_q < prod_c_q));

  // Sequencer and datapath next values
  always_comb begin
    state_d     = state_q;
    r_d         = r_q;
    base_d      = base_q;
    idx_d       = idx_q;
    n_d         = n_q;
    closing_d   = closing_q;
    parity_d    = parity_q;
    hdr_valid_d = hdr_valid_q;
    m_valid_d   = m_valid_q;
    px_d        = px_q;
    py_d        = py_q;
    label_d     = label_q;
    v0x_d       = v0x_q;
    v0y_d       = v0y_q;
    curx_d      = curx_q;
    cury_d      = cury_q;
    xl_d        = xl_q;
    yl_d        = yl_q;
    xh_d        = xh_q;
    yh_d        = yh_q;
    mag_a_d     = mag_a_q;
    sign_a_d    = sign_a_q;
    mag_c_d     = mag_c_q;
    sign_c_d    = sign_c_q;
    dy_d        = dy_q;
    d_d         = d_q;
    prod_a_d    = prod_a_q;
    prod_c_d    = prod_c_q;
    res_found_d = res_found_q;
    m_label_d   = m_label_q;
    m_found_d   = m_found_q;

    // Drop the result beat once taken
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (s_axis_tuser)
            OP_WR_HEADER: begin
              if (region_ok) begin
                hdr_valid_d[wr_r] = 1'b1;
              end
            end
            OP_QUERY: begin
              px_d    = in_px;
              py_d    = in_py;
              r_d     = '0;
              base_d  = '0;
              state_d = ST_HDR;
            end
            default: ;
          endcase
        end
      end
      ST_HDR: begin
        state_d = ST_HCHK;
      end
      ST_HCHK: begin
        label_d  = hram_rdata[HW-1:CW];
        n_d      = n_rd;
        parity_d = 1'b0;
        if (n_rd == '0) begin
          state_d = ST_NXR;
        end else begin
          state_d = ST_V0;
        end
      end
      ST_V0: begin
        v0x_d     = vram_rdata[COORD_W-1:0];
        v0y_d     = vram_rdata[2*COORD_W-1:COORD_W];
        curx_d    = vram_rdata[COORD_W-1:0];
        cury_d    = vram_rdata[2*COORD_W-1:COORD_W];
        idx_d     = adv_k;
        closing_d = adv_last;
        state_d   = ST_LOAD;
      end
      ST_LOAD: begin
        // Order endpoints so that h is the one above py
        if (gt0) begin
          xh_d = curx_q;
          yh_d = cury_q;
          xl_d = e1x;
          yl_d = e1y;
        end else begin
          xl_d = curx_q;
          yl_d = cury_q;
          xh_d = e1x;
          yh_d = e1y;
        end
        curx_d  = e1x;
        cury_d  = e1y;
        state_d = straddle ? ST_DIFF : ST_ENDE;
      end
      ST_DIFF: begin
        sign_a_d = a_w[COORD_W];
        mag_a_d  = a_w[COORD_W] ? a_neg[COORD_W-1:0] : a_w[COORD_W-1:0];
        sign_c_d = c_w[COORD_W];
        mag_c_d  = c_w[COORD_W] ? c_neg[COORD_W-1:0] : c_w[COORD_W-1:0];
        dy_d     = dy_w[COORD_W-1:0];
        d_d      = d_w[COORD_W-1:0];
        state_d  = ST_MULA;
      end
      ST_MULA: begin
        prod_a_d = mul_p;
        state_d  = ST_MULC;
      end
      ST_MULC: begin
        prod_c_d = mul_p;
        state_d  = ST_CMP;
      end
      ST_CMP: begin
        parity_d = parity_q ^ less;
        state_d  = ST_ENDE;
      end
      ST_ENDE: begin
        if (closing_q) begin
          if (parity_q) begin
            res_found_d = 1'b1;
            state_d     = ST_DONE;
          end else begin
            state_d = ST_NXR;
          end
        end else begin
          idx_d     = adv_k;
          closing_d = adv_last;
          state_d   = ST_LOAD;
        end
      end
      ST_NXR: begin
        if (r_last) begin
          res_found_d = 1'b0;
          state_d     = ST_DONE;
        end else begin
          r_d     = r_q + RW'(1);
          base_d  = base_q + VA'(MAX_VERTICES);
          state_d = ST_HDR;
        end
      end
      ST_DONE: begin
        // Post the result once the output register is free
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_found_d = res_found_q;
          m_label_d = res_found_q ? label_q : '0;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      r_q         <= '0;
      base_q      <= '0;
      idx_q       <= '0;
      n_q         <= '0;
      closing_q   <= 1'b0;
      parity_q    <= 1'b0;
      hdr_valid_q <= '0;
      m_valid_q   <= 1'b0;
      res_found_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      r_q         <= r_d;
      base_q      <= base_d;
      idx_q       <= idx_d;
      n_q         <= n_d;
      closing_q   <= closing_d;
      parity_q    <= parity_d;
      hdr_valid_q <= hdr_valid_d;
      m_valid_q   <= m_valid_d;
      res_found_q <= res_found_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    px_q      <= px_d;
    py_q      <= py_d;
    label_q   <= label_d;
    v0x_q     <= v0x_d;
    v0y_q     <= v0y_d;
    curx_q    <= curx_d;
    cury_q    <= cury_d;
    xl_q      <= xl_d;
    yl_q      <= yl_d;
    xh_q      <= xh_d;
    yh_q      <= yh_d;
    mag_a_q   <= mag_a_d;
    sign_a_q  <= sign_a_d;
    mag_c_q   <= mag_c_d;
    sign_c_q  <= sign_c_d;
    dy_q      <= dy_d;
    d_q       <= d_d;
    prod_a_q  <= prod_a_d;
    prod_c_q  <= prod_c_d;
    m_label_q <= m_label_d;
    m_found_q <= m_found_d;
  end

  // Vertex storage: {y, x} per slot region * MAX_VERTICES + vertex
  pir_ram #(
    .WIDTH (2 * COORD_W),
    .DEPTH (VDEPTH)
  ) u_vertex_ram (
    .clk_i   (clk_i),
    .we_i    (vram_we),
    .waddr_i (vram_waddr),
    .wdata_i (vram_wdata),
    .re_i    (vram_re),
    .raddr_i (vram_raddr),
    .rdata_o (vram_rdata)
  );

  // Region headers: {label, count}
  pir_ram #(
    .WIDTH (HW),
    .DEPTH (REGIONS)
  ) u_header_ram (
    .clk_i   (clk_i),
    .we_i    (hram_we),
    .waddr_i (hram_waddr),
    .wdata_i (hram_wdata),
    .re_i    (hram_re),
    .raddr_i (r_q),
    .rdata_o (hram_rdata)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_found_q;
  assign m_axis_tdata  = M_TDATA_W'(m_label_q);

endmodule

// File: src/pir_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Used for vertex and region header storage of the classifier.
// No dependencies.
module pir_ram #(
  parameter int  WIDTH = 32,
  parameter int  DEPTH = 64,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
